// ===== hw/rtl/rcm_pkg.sv =====
`default_nettype none
package rcm_pkg;

    localparam int ADC_BITS_DEF = 12;
    localparam int MAX_WINDOW   = 4096;

    localparam int WIN_W      = 13;
    localparam int GAIN_W     = 24;
    localparam int OFFS_W     = 22;
    localparam int CUR_W      = 22;
    localparam int SMOOTH_W   = 17;
    localparam int FRAC_W     = 16;
    localparam int SUM_W      = 37;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 3;

    localparam int ROOT_W     = (SUM_W + 1) / 2;
    localparam int RAD_W      = 2 * ROOT_W;
    localparam int SREM_W     = ROOT_W + 2;
    localparam int PROD_W     = ROOT_W + GAIN_W;
    localparam int SCALED_W   = PROD_W - 8;
    localparam int SPROD_W    = SMOOTH_W + CUR_W;

    localparam int DIV_STEPS  = SUM_W;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    localparam logic [SUM_W-1:0]    SUM_MAX = {SUM_W{1'b1}};
    localparam logic [CUR_W-1:0]    CUR_MAX = {CUR_W{1'b1}};
    localparam logic [SMOOTH_W-1:0] ONE_Q16 = SMOOTH_W'(1 << FRAC_W);

    localparam logic [WIN_W-1:0]    WINDOW_LENGTH_RST = WIN_W'(500);
    localparam logic [GAIN_W-1:0]   GAIN_RST          = GAIN_W'(216324);
    localparam logic [OFFS_W-1:0]   OFFSET_RST        = OFFS_W'(665190);
    localparam logic [CUR_W-1:0]    ZERO_THR_RST      = CUR_W'(6554);
    localparam logic [SMOOTH_W-1:0] SMOOTHING_RST     = SMOOTH_W'(6554);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_LENGTH = 3'd0,
        CFG_GAIN          = 3'd1,
        CFG_OFFSET        = 3'd2,
        CFG_ZERO_THR      = 3'd3,
        CFG_SMOOTHING     = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic load_in;
        logic square;
        logic accum;
        logic div_init;
        logic div_step;
        logic sqrt_init;
        logic sqrt_step;
        logic scale;
        logic offset;
        logic smooth_mul;
        logic emit;
    } rcm_cmd_t;

    typedef struct packed {
        logic window_done;
        logic out_busy;
    } rcm_status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/rcm_ctrl.sv =====
`default_nettype none
module rcm_ctrl import rcm_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire rcm_status_t status,
    output rcm_cmd_t         cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ACCUM,
        ST_DIV_INIT,
        ST_DIV,
        ST_SQRT_INIT,
        ST_SQRT,
        ST_SCALE,
        ST_OFFSET,
        ST_SMOOTH_MUL,
        ST_EMIT
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                cmd.load_in = s_valid;
                if (s_valid) begin
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                cmd.square = 1'b1;
                state_next = ST_ACCUM;
            end
            ST_ACCUM: begin
                cmd.accum  = 1'b1;
                state_next = status.window_done ? ST_DIV_INIT : ST_IDLE;
            end
            ST_DIV_INIT: begin
                cmd.div_init = 1'b1;
                step_next    = '0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                    state_next = ST_SQRT_INIT;
                end
            end
            ST_SQRT_INIT: begin
                cmd.sqrt_init = 1'b1;
                step_next     = '0;
                state_next    = ST_SQRT;
            end
            ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                step_next     = step_reg + 1'b1;
                if (step_reg == STEP_W'(SQRT_STEPS - 1)) begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = ST_OFFSET;
            end
            ST_OFFSET: begin
                cmd.offset = 1'b1;
                state_next = ST_SMOOTH_MUL;
            end
            ST_SMOOTH_MUL: begin
                cmd.smooth_mul = 1'b1;
                state_next     = ST_EMIT;
            end
            ST_EMIT: begin
                cmd.emit = !status.out_busy;
                if (!status.out_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/rcm_datapath.sv =====
`default_nettype none
module rcm_datapath import rcm_pkg::*; #(
    parameter int ADC_BITS = ADC_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic [ADC_BITS-1:0]   s_sensor_sample,
    input  wire logic [ADC_BITS-1:0]   s_reference_sample,
    input  wire rcm_cmd_t              cmd,
    output rcm_status_t                status,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [CUR_W-1:0]           m_window_current,
    output logic [CUR_W-1:0]           m_smoothed_current
);

    localparam int SQ_W = 2 * ADC_BITS;

    logic [WIN_W-1:0]    window_length_reg;
    logic [GAIN_W-1:0]   gain_reg;
    logic [OFFS_W-1:0]   offset_reg;
    logic [CUR_W-1:0]    zero_thr_reg;
    logic [SMOOTH_W-1:0] smoothing_reg;

    logic [ADC_BITS-1:0] sensor_reg, reference_reg;
    logic [SQ_W-1:0]     sq_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [WIN_W-1:0]    count_reg;
    logic [SUM_W-1:0]    div_q_reg;
    logic [WIN_W-1:0]    div_rem_reg;
    logic [WIN_W-1:0]    div_d_reg;
    logic [RAD_W-1:0]    rad_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [SREM_W-1:0]   srem_reg;
    logic [SCALED_W-1:0] scaled_reg;
    logic [CUR_W-1:0]    win_reg;
    logic [SPROD_W-1:0]  p_new_reg, p_old_reg;
    logic [CUR_W-1:0]    smoothed_reg;
    logic [CUR_W-1:0]    m_window_reg, m_smoothed_reg;
    logic                m_valid_reg;

    logic signed [ADC_BITS:0]  diff;
    logic [ADC_BITS:0]         mag_full;
    logic [ADC_BITS-1:0]       mag;
    logic [SQ_W-1:0]           sq;
    logic [SUM_W:0]            sum_ext;
    logic [SUM_W-1:0]          sum_next;
    logic [WIN_W-1:0]          count_inc;
    logic [WIN_W-1:0]          len_eff;
    logic [WIN_W:0]            div_trial, div_diff;
    logic                      div_ge;
    logic [SREM_W+1:0]         s_r, s_trial, s_diff;
    logic                      s_ge;
    logic [PROD_W-1:0]         prod;
    logic signed [SCALED_W:0]  cur, thr_s, max_s;
    logic [CUR_W-1:0]          win_next;
    logic [SMOOTH_W-1:0]       f;
    logic [SPROD_W:0]          s_sum;
    logic [CUR_W-1:0]          s_next;

    always_comb begin
        diff     = $signed({1'b0, sensor_reg}) - $signed({1'b0, reference_reg});
        mag_full = diff[ADC_BITS] ? unsigned'(-diff) : unsigned'(diff);
        mag      = mag_full[ADC_BITS-1:0];
        sq       = SQ_W'(mag) * SQ_W'(mag);
    end

    always_comb begin
        if (window_length_reg == '0) begin
            len_eff = WIN_W'(1);
        end else if (int'(window_length_reg) > MAX_WINDOW) begin
            len_eff = WIN_W'(MAX_WINDOW);
        end else begin
            len_eff = window_length_reg;
        end
        sum_ext   = {1'b0, sum_reg} + (SUM_W + 1)'(sq_reg);
        sum_next  = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
        count_inc = count_reg + 1'b1;
    end

    assign status.window_done = (count_inc >= len_eff);
    assign status.out_busy    = m_valid_reg && !m_ready;

    always_comb begin
        div_trial = {div_rem_reg, div_q_reg[SUM_W-1]};
        div_diff  = div_trial - {1'b0, div_d_reg};
        div_ge    = (div_trial >= {1'b0, div_d_reg});
    end

    always_comb begin
        s_r     = {srem_reg, rad_reg[RAD_W-1 -: 2]};
        s_trial = (SREM_W + 2)'({root_reg, 2'b01});
        s_diff  = s_r - s_trial;
        s_ge    = (s_r >= s_trial);
    end

    assign prod = PROD_W'(root_reg) * PROD_W'(gain_reg);

    always_comb begin
        cur   = $signed({1'b0, scaled_reg}) - $signed((SCALED_W + 1)'(offset_reg));
        thr_s = $signed((SCALED_W + 1)'(zero_thr_reg));
        max_s = $signed((SCALED_W + 1)'(CUR_MAX));
        if (cur <= thr_s) begin
            win_next = '0;
        end else if (cur > max_s) begin
            win_next = CUR_MAX;
        end else begin
            win_next = cur[CUR_W-1:0];
        end
    end

    always_comb begin
        f      = (smoothing_reg > ONE_Q16) ? ONE_Q16 : smoothing_reg;
        s_sum  = (SPROD_W + 1)'(p_new_reg) + (SPROD_W + 1)'(p_old_reg);
        s_next = s_sum[FRAC_W +: CUR_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_length_reg <= WINDOW_LENGTH_RST;
            gain_reg          <= GAIN_RST;
            offset_reg        <= OFFSET_RST;
            zero_thr_reg      <= ZERO_THR_RST;
            smoothing_reg     <= SMOOTHING_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_WINDOW_LENGTH: window_length_reg <= cfg_wdata[WIN_W-1:0];
                CFG_GAIN:          gain_reg          <= cfg_wdata[GAIN_W-1:0];
                CFG_OFFSET:        offset_reg        <= cfg_wdata[OFFS_W-1:0];
                CFG_ZERO_THR:      zero_thr_reg      <= cfg_wdata[CUR_W-1:0];
                CFG_SMOOTHING:     smoothing_reg     <= cfg_wdata[SMOOTH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg      <= '0;
            count_reg    <= '0;
            smoothed_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cmd.accum) begin
                sum_reg   <= sum_next;
                count_reg <= count_inc;
            end else if (cmd.div_init) begin
                sum_reg   <= '0;
                count_reg <= '0;
            end
            if (cmd.emit) begin
                smoothed_reg <= s_next;
                m_valid_reg  <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            sensor_reg    <= s_sensor_sample;
            reference_reg <= s_reference_sample;
        end
        if (cmd.square) begin
            sq_reg <= sq;
        end
        if (cmd.div_init) begin
            div_q_reg   <= sum_reg;
            div_rem_reg <= '0;
            div_d_reg   <= count_reg;
        end else if (cmd.div_step) begin
            div_q_reg   <= {div_q_reg[SUM_W-2:0], div_ge};
            div_rem_reg <= div_ge ? div_diff[WIN_W-1:0] : div_trial[WIN_W-1:0];
        end
        if (cmd.sqrt_init) begin
            rad_reg  <= RAD_W'(div_q_reg);
            root_reg <= '0;
            srem_reg <= '0;
        end else if (cmd.sqrt_step) begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            root_reg <= {root_reg[ROOT_W-2:0], s_ge};
            srem_reg <= s_ge ? s_diff[SREM_W-1:0] : s_r[SREM_W-1:0];
        end
        if (cmd.scale) begin
            scaled_reg <= prod[PROD_W-1:8];
        end
        if (cmd.offset) begin
            win_reg <= win_next;
        end
        if (cmd.smooth_mul) begin
            p_new_reg <= SPROD_W'(f) * SPROD_W'(win_reg);
            p_old_reg <= SPROD_W'(ONE_Q16 - f) * SPROD_W'(smoothed_reg);
        end
        if (cmd.emit) begin
            m_window_reg   <= win_reg;
            m_smoothed_reg <= s_next;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_window_current   = m_window_reg;
    assign m_smoothed_current = m_smoothed_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/rms_current_meter.sv =====
`default_nettype none
// A sample that does not close a window passes through the square and accumulate states,
// then the block takes the next sample. A window-closing sample runs the 37-step restoring
// divider and the 19-step square root before its result is registered; the result register
// then frees the input side while the result waits.
// Reset is synchronous and active low: configuration returns to its defaults, and the sum,
// count, smoothed value and output valid clear at once.
module rms_current_meter import rcm_pkg::*; #(
    parameter int ADC_BITS = ADC_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [ADC_BITS-1:0]   s_sensor_sample,
    input  wire logic [ADC_BITS-1:0]   s_reference_sample,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [CUR_W-1:0]           m_window_current,
    output logic [CUR_W-1:0]           m_smoothed_current
);

    rcm_cmd_t    cmd;
    rcm_status_t status;

    rcm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    rcm_datapath #(
        .ADC_BITS (ADC_BITS)
    ) u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .s_sensor_sample    (s_sensor_sample),
        .s_reference_sample (s_reference_sample),
        .cmd                (cmd),
        .status             (status),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_window_current   (m_window_current),
        .m_smoothed_current (m_smoothed_current)
    );

endmodule
`default_nettype wire

// ===== tb/rms_current_meter_test.sv =====
`timescale 1ns / 1ps
module rms_current_meter_test;
    import rcm_pkg::*;

    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 70;
    localparam int RANDOM_ITEMS  = 720;
    localparam int REPORT_LIMIT  = 10;

    typedef struct {
        logic [CUR_W-1:0] window_current;
        logic [CUR_W-1:0] smoothed_current;
    } reading_t;

    class rms_reading_book;
        logic [WIN_W-1:0]    window_length;
        logic [GAIN_W-1:0]   gain;
        logic [OFFS_W-1:0]   offset;
        logic [CUR_W-1:0]    threshold;
        logic [SMOOTH_W-1:0] smoothing;
        logic [SUM_W-1:0]    square_sum;
        logic [WIN_W-1:0]    sample_count;
        logic [CUR_W-1:0]    smoothed;
        reading_t            due[$];
        int unsigned         mismatches;

        function new();
            window_length = WINDOW_LENGTH_RST;
            gain          = GAIN_RST;
            offset        = OFFSET_RST;
            threshold     = ZERO_THR_RST;
            smoothing     = SMOOTHING_RST;
            square_sum    = '0;
            sample_count  = '0;
            smoothed      = '0;
            mismatches    = 0;
        endfunction

        function void set_register(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_WINDOW_LENGTH: window_length = data[WIN_W-1:0];
                CFG_GAIN:          gain = data[GAIN_W-1:0];
                CFG_OFFSET:        offset = data[OFFS_W-1:0];
                CFG_ZERO_THR:      threshold = data[CUR_W-1:0];
                CFG_SMOOTHING:     smoothing = data[SMOOTH_W-1:0];
                default:           ;
            endcase
        endfunction

        function int unsigned span();
            if (window_length == 0) begin
                return 1;
            end
            return (window_length > MAX_WINDOW) ? MAX_WINDOW : int'(window_length);
        endfunction

        function int unsigned pending();
            return due.size();
        endfunction

        function logic [ROOT_W-1:0] floor_root(logic [SUM_W-1:0] value);
            logic [ROOT_W-1:0] root;
            logic [ROOT_W-1:0] trial;
            root = '0;
            for (int b = ROOT_W - 1; b >= 0; b--) begin
                trial = root | (ROOT_W'(1) << b);
                if (64'(trial) * 64'(trial) <= 64'(value)) begin
                    root = trial;
                end
            end
            return root;
        endfunction

        function void note_sample(logic [ADC_BITS_DEF-1:0] sensor,
                                  logic [ADC_BITS_DEF-1:0] reference);
            logic signed [ADC_BITS_DEF:0] diff;
            logic [ADC_BITS_DEF-1:0]      mag;
            logic [2*ADC_BITS_DEF-1:0]    square;
            logic [SUM_W:0]               wide_sum;
            logic [SUM_W-1:0]             mean;
            logic [63:0]                  scaled;
            logic [63:0]                  blend;
            longint                       current;
            logic [CUR_W-1:0]             win;
            logic [SMOOTH_W-1:0]          weight;
            reading_t                     reading;
            diff = $signed({1'b0, sensor}) - $signed({1'b0, reference});
            mag = diff[ADC_BITS_DEF] ? ADC_BITS_DEF'(-diff) : ADC_BITS_DEF'(diff);
            square = (2 * ADC_BITS_DEF)'(mag) * (2 * ADC_BITS_DEF)'(mag);
            wide_sum = {1'b0, square_sum} + (SUM_W + 1)'(square);
            square_sum = wide_sum[SUM_W] ? SUM_MAX : wide_sum[SUM_W-1:0];
            sample_count = sample_count + 1'b1;
            if (32'(sample_count) < span()) begin
                return;
            end
            mean = (sample_count != 0) ? square_sum / SUM_W'(sample_count) : '0;
            scaled = (64'(floor_root(mean)) * 64'(gain)) >> 8;
            current = longint'(scaled) - longint'(offset);
            if (current <= longint'(threshold)) begin
                win = '0;
            end else if (current > longint'(CUR_MAX)) begin
                win = CUR_MAX;
            end else begin
                win = current[CUR_W-1:0];
            end
            weight = (smoothing > ONE_Q16) ? ONE_Q16 : smoothing;
            blend = (64'(weight) * 64'(win) + 64'(ONE_Q16 - weight) * 64'(smoothed)) >> 16;
            smoothed = blend[CUR_W-1:0];
            reading.window_current = win;
            reading.smoothed_current = smoothed;
            due.push_back(reading);
            square_sum = '0;
            sample_count = '0;
        endfunction

        function void check_reading(logic [CUR_W-1:0] window_current,
                                    logic [CUR_W-1:0] smoothed_current);
            reading_t wanted;
            if (due.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("Unexpected reading: window_current %0d smoothed_current %0d",
                             window_current, smoothed_current);
                end
                return;
            end
            wanted = due.pop_front();
            if (window_current !== wanted.window_current ||
                smoothed_current !== wanted.smoothed_current) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("Reading mismatch: window_current exp %0d got %0d, %s %0d got %0d",
                             wanted.window_current, window_current,
                             "smoothed_current exp", wanted.smoothed_current,
                             smoothed_current);
                end
            end
        endfunction
    endclass

    logic                     aclk;
    logic                     aresetn;
    logic                     cfg_we;
    cfg_index_t               cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_wdata;
    logic                     s_valid;
    logic                     s_ready;
    logic [ADC_BITS_DEF-1:0]  s_sensor_sample;
    logic [ADC_BITS_DEF-1:0]  s_reference_sample;
    logic                     m_valid;
    logic                     m_ready;
    logic [CUR_W-1:0]         m_window_current;
    logic [CUR_W-1:0]         m_smoothed_current;

    rms_reading_book readings = new();
    bit              steady_flow = 1'b0;
    int unsigned     quiet_cycles = 0;

    rms_current_meter i_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_sensor_sample    (s_sensor_sample),
        .s_reference_sample (s_reference_sample),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_window_current   (m_window_current),
        .m_smoothed_current (m_smoothed_current)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    // The run is abandoned when no transfer or register write happens for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_register(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        readings.set_register(idx, data);
    endtask

    task automatic apply_setting(input logic [CFG_DATA_W-1:0] span_data,
                                 input logic [CFG_DATA_W-1:0] gain_data,
                                 input logic [CFG_DATA_W-1:0] offset_data,
                                 input logic [CFG_DATA_W-1:0] threshold_data,
                                 input logic [CFG_DATA_W-1:0] smooth_data);
        write_register(CFG_WINDOW_LENGTH, span_data);
        write_register(CFG_GAIN, gain_data);
        write_register(CFG_OFFSET, offset_data);
        write_register(CFG_ZERO_THR, threshold_data);
        write_register(CFG_SMOOTHING, smooth_data);
        cfg_we <= 1'b0;
    endtask

    task automatic send_sample(input logic [ADC_BITS_DEF-1:0] sensor,
                               input logic [ADC_BITS_DEF-1:0] reference);
        int unsigned gap;
        gap = steady_flow ? 0 : $urandom_range(0, 17);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_sensor_sample <= sensor;
        s_reference_sample <= reference;
        do @(posedge aclk); while (s_ready !== 1'b1);
        readings.note_sample(sensor, reference);
    endtask

    task automatic send_random(input int unsigned count);
        logic [ADC_BITS_DEF-1:0] sensor;
        logic [ADC_BITS_DEF-1:0] reference;
        int unsigned             base;
        repeat (count) begin
            case ($urandom_range(0, 3))
                0: begin
                    sensor = ADC_BITS_DEF'($urandom);
                    reference = ADC_BITS_DEF'($urandom);
                end
                1: begin
                    base = $urandom_range(200, 3895);
                    reference = ADC_BITS_DEF'(base);
                    sensor = ADC_BITS_DEF'(base + $urandom_range(0, 400) - 200);
                end
                2: begin
                    sensor = {ADC_BITS_DEF{1'($urandom)}};
                    reference = {ADC_BITS_DEF{1'($urandom)}};
                end
                default: begin
                    sensor = ADC_BITS_DEF'($urandom);
                    reference = ADC_BITS_DEF'(2048);
                end
            endcase
            send_sample(sensor, reference);
        end
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (readings.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int unsigned gap;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            gap = steady_flow ? 0 : $urandom_range(0, 17);
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            readings.check_reading(m_window_current, m_smoothed_current);
        end
    end

    initial begin
        logic [CFG_DATA_W-1:0] span_data;
        logic [CFG_DATA_W-1:0] gain_data;
        logic [CFG_DATA_W-1:0] offset_data;
        logic [CFG_DATA_W-1:0] threshold_data;
        logic [CFG_DATA_W-1:0] smooth_data;
        int unsigned           random_items;
        int unsigned           span;
        int unsigned           count;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_WINDOW_LENGTH;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_sensor_sample = '0;
        s_reference_sample = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // One full window with the register defaults.
        send_random(500);
        wait_idle();

        apply_setting(1, 24'hFFFFFF, 0, 0, 65536);
        send_sample(4095, 0);
        send_sample(0, 4095);
        send_sample(0, 0);
        send_sample(4095, 4095);
        send_sample(2048, 2047);
        wait_idle();

        apply_setting(0, GAIN_RST, 0, 24'h3FFFFF, 0);
        send_sample(4095, 0);
        send_sample(1, 0);
        wait_idle();

        apply_setting(24'hFFE002, 24'h100000, 24'h3FFFFF, 0, 24'h01FFFF);
        send_sample(3000, 100);
        send_sample(100, 3000);
        wait_idle();

        apply_setting(3, 24'h010000, 100, 6554, 24'hFFFFFF);
        send_sample(4095, 2048);
        send_sample(2048, 4095);
        send_sample(12'hAAA, 12'h555);
        wait_idle();

        // The window is shortened below the count already gathered.
        apply_setting(10, GAIN_RST, 0, 0, 6554);
        send_random(6);
        wait_idle();
        apply_setting(4, GAIN_RST, 0, 0, 6554);
        send_sample(12'h555, 12'hAAA);
        wait_idle();

        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       span_data = 0;
                1:       span_data = CFG_DATA_W'($urandom_range(17, 300));
                default: span_data = CFG_DATA_W'($urandom_range(1, 16));
            endcase
            span_data = span_data | (CFG_DATA_W'($urandom) & 24'hFFE000);
            case ($urandom_range(0, 2))
                0:       gain_data = CFG_DATA_W'($urandom);
                1:       gain_data = CFG_DATA_W'($urandom_range(0, 1 << 20));
                default: gain_data = CFG_DATA_W'($urandom_range(150000, 300000));
            endcase
            case ($urandom_range(0, 2))
                0:       offset_data = CFG_DATA_W'($urandom);
                1:       offset_data = CFG_DATA_W'($urandom_range(0, 1 << 18));
                default: offset_data = 0;
            endcase
            case ($urandom_range(0, 2))
                0:       threshold_data = CFG_DATA_W'($urandom);
                1:       threshold_data = CFG_DATA_W'($urandom_range(0, 1 << 16));
                default: threshold_data = CFG_DATA_W'($urandom_range(0, 100));
            endcase
            case ($urandom_range(0, 3))
                0:       smooth_data = CFG_DATA_W'($urandom);
                default: smooth_data = CFG_DATA_W'($urandom_range(0, 65536));
            endcase
            apply_setting(span_data, gain_data, offset_data, threshold_data, smooth_data);
            span = readings.span();
            count = span * $urandom_range(1, 4) + $urandom_range(0, span - 1);
            steady_flow = ($urandom_range(0, 3) == 0);
            send_random(count);
            wait_idle();
            random_items += count;
        end
        steady_flow = 1'b0;

        // Close any partial window with a window length of one and the other registers at their defaults.
        apply_setting(1, GAIN_RST, CFG_DATA_W'(OFFSET_RST), CFG_DATA_W'(ZERO_THR_RST),
                      CFG_DATA_W'(SMOOTHING_RST));
        send_sample(0, 0);
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (readings.mismatches == 0 && readings.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
